// ===== rtl/c8_pkg.sv =====
// c8_pkg: shared types, constants and the hex font for the chip8 core
// no dependencies
package c8_pkg;

  localparam int unsigned MemBytes   = 4096;
  localparam int unsigned ScreenW    = 64;
  localparam int unsigned ScreenH    = 32;
  localparam int unsigned StackDepth = 16;
  localparam int unsigned FontBytes  = 80;
  localparam logic [11:0] PcReset    = 12'h200;

  localparam logic [1:0] FuncLoad  = 2'd0;
  localparam logic [1:0] FuncExec  = 2'd1;
  localparam logic [1:0] FuncPixel = 2'd2;
  localparam logic [1:0] FuncNone  = 2'd3;

  // top nibble of an opcode
  typedef enum logic [3:0] {
    OpSys, OpJump, OpCall, OpSkipEqImm, OpSkipNeImm, OpSkipEqReg, OpLoadImm, OpAddImm,
    OpAlu, OpSkipNeReg, OpLoadIndex, OpJumpV0, OpRand, OpDraw, OpKey, OpMisc
  } op_group_e;

  // sub-opcodes
  localparam logic [7:0] SysCls = 8'hE0, SysRet = 8'hEE;
  localparam logic [3:0] AluMov = 4'h0, AluOr = 4'h1, AluAnd = 4'h2, AluXor = 4'h3,
                         AluAdd = 4'h4, AluSub = 4'h5, AluShr = 4'h6, AluSubn = 4'h7,
                         AluShl = 4'hE;
  localparam logic [7:0] KeySkp = 8'h9E, KeySknp = 8'hA1;
  localparam logic [7:0] MiscGetDt = 8'h07, MiscWaitKey = 8'h0A, MiscSetDt = 8'h15,
                         MiscSetSt = 8'h18, MiscAddI = 8'h1E, MiscFont = 8'h29,
                         MiscBcd = 8'h33, MiscStore = 8'h55, MiscLoad = 8'h65;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] load_address;
    logic [7:0]  load_byte;
    logic [5:0]  pixel_x;
    logic [4:0]  pixel_y;
    logic [15:0] key_states;
    logic [7:0]  random_value;
  } in_beat_t;

  typedef struct packed {
    logic [11:0] program_counter;
    logic [15:0] opcode;
    logic        pixel_value;
    logic        screen_changed;
    logic        beep;
    logic        bad_opcode;
  } out_beat_t;

  typedef enum logic [4:0] {
    StIdle, StClear, StClrFb, StFetchHi, StFetchLo, StOpLo, StExec,
    StFbRead, StFbWait,
    StDrawMem, StDrawMemW, StDrawRow, StDrawPix, StDrawPixW,
    StBcd, StStore, StLoad, StLoadW, StPixW, StTimers, StDone
  } state_e;

  function automatic logic [7:0] font_byte(input logic [6:0] a);
    logic [7:0] f [FontBytes];
    f = '{8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
          8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
          8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
          8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
          8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
          8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
          8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
          8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80};
    if (a < 7'(FontBytes)) font_byte = f[a];
    else font_byte = 8'h00;
  endfunction

endpackage

// ===== rtl/c8_ram.sv =====
// c8_ram: generic single-port ram with registered read
// no dependencies
module c8_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

// ===== rtl/chip8_interpreter_core.sv =====
// chip8_interpreter_core: sequenced chip8 machine around one shared alu
// depends on c8_pkg and c8_ram
//
// After reset the block sweeps memory (font into the first 80 bytes, zero
// elsewhere) and the frame buffer, taking no beat meanwhile. The result of a
// load beat is delivered after the StDone state, and that of a pixel read
// after StFbRead, StPixW and StDone. An execute beat steps through StFetchHi,
// StFetchLo, StOpLo, StExec, StTimers and StDone plus per-opcode work on the
// single-port memories: clear screen, sprite draw per row and per set sprite
// pixel that lands on screen (up to 15 rows), bcd, and register store and
// register load per register. One result register holds the finished beat;
// the next beat is taken from the cycle after it has been delivered.
module chip8_interpreter_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  c8_pkg::in_beat_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output c8_pkg::out_beat_t out_data_o
);
  c8_pkg::state_e st_q, st_d;
  c8_pkg::in_beat_t in_q, in_d;
  c8_pkg::out_beat_t res_q, res_d;
  logic out_v_q, out_v_d;

  logic [7:0]  v_q [16];
  logic [7:0]  v_d [16];
  logic [11:0] stk_q [16];
  logic [11:0] stk_d [16];
  logic [3:0]  sp_q, sp_d;
  logic [11:0] pc_q, pc_d;
  logic [15:0] i_q, i_d;
  logic [7:0]  dt_q, dt_d, snd_q, snd_d;
  logic [15:0] op_q, op_d;
  logic [11:0] cnt_q, cnt_d;   // sweep address, row or register counter
  logic [2:0]  col_q, col_d;
  logic [7:0]  bits_q, bits_d;
  logic        chg_q, chg_d;
  logic        ph_q, ph_d;     // read phase helper for pixel toggle and register load
  logic        coll_q, coll_d; // sprite collision seen, lands in vf at the end

  // memory ports
  logic        m_we, f_we;
  logic [11:0] m_addr;
  logic [7:0]  m_wd, m_rd;
  logic [10:0] f_addr;
  logic        f_wd, f_rd;

  c8_ram #(.Width(8), .Depth(c8_pkg::MemBytes)) u_mem (
    .clk_i, .we_i(m_we), .addr_i(m_addr), .wdata_i(m_wd), .rdata_o(m_rd));
  c8_ram #(.Width(1), .Depth(c8_pkg::ScreenW * c8_pkg::ScreenH)) u_fb (
    .clk_i, .we_i(f_we), .addr_i(f_addr), .wdata_i(f_wd), .rdata_o(f_rd));

  logic [3:0] x, y;
  logic [7:0] vx, vy;
  logic [8:0] row_pos, col_pos;
  logic [7:0] bcd_h, bcd_t, bcd_o;
  logic [8:0] rnd9;

  always_comb begin
    x  = op_q[11:8];
    y  = op_q[7:4];
    vx = v_q[x];
    vy = v_q[y];
    row_pos = {1'b0, vy} + {1'b0, cnt_q[7:0]};
    col_pos = {1'b0, vx} + {6'd0, col_q};
    // bcd digits by compare-and-subtract
    bcd_h = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
    bcd_o = vx - 8'((bcd_h * 8'd100));
    bcd_t = (bcd_o >= 8'd90) ? 8'd9 : (bcd_o >= 8'd80) ? 8'd8 :
            (bcd_o >= 8'd70) ? 8'd7 : (bcd_o >= 8'd60) ? 8'd6 :
            (bcd_o >= 8'd50) ? 8'd5 : (bcd_o >= 8'd40) ? 8'd4 :
            (bcd_o >= 8'd30) ? 8'd3 : (bcd_o >= 8'd20) ? 8'd2 :
            (bcd_o >= 8'd10) ? 8'd1 : 8'd0;
    rnd9 = (in_q.random_value == 8'hFF) ? 9'd0 : {1'b0, in_q.random_value};
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= c8_pkg::StClear;
      out_v_q <= 1'b0;
      sp_q <= '0;
      pc_q <= c8_pkg::PcReset;
      i_q <= '0;
      dt_q <= '0;
      snd_q <= '0;
      cnt_q <= '0;
      for (int k = 0; k < 16; k++) begin
        v_q[k] <= '0;
        stk_q[k] <= '0;
      end
    end else begin
      st_q <= st_d;
      out_v_q <= out_v_d;
      sp_q <= sp_d;
      pc_q <= pc_d;
      i_q <= i_d;
      dt_q <= dt_d;
      snd_q <= snd_d;
      cnt_q <= cnt_d;
      v_q <= v_d;
      stk_q <= stk_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    in_q <= in_d;
    res_q <= res_d;
    op_q <= op_d;
    col_q <= col_d;
    bits_q <= bits_d;
    chg_q <= chg_d;
    ph_q <= ph_d;
    coll_q <= coll_d;
  end

  // sequencer
  always_comb begin
    logic [12:0] sum;
    logic [8:0]  a9;
    st_d = st_q; in_d = in_q; res_d = res_q; out_v_d = out_v_q;
    v_d = v_q; stk_d = stk_q; sp_d = sp_q; pc_d = pc_q; i_d = i_q;
    dt_d = dt_q; snd_d = snd_q; op_d = op_q; cnt_d = cnt_q; col_d = col_q;
    bits_d = bits_q; chg_d = chg_q; ph_d = ph_q; coll_d = coll_q;
    m_we = 1'b0; m_addr = pc_q; m_wd = '0;
    f_we = 1'b0; f_addr = {in_q.pixel_y, in_q.pixel_x}; f_wd = 1'b0;
    in_ready_o = 1'b0;
    sum = '0; a9 = '0;
    if (out_v_q && out_ready_i) out_v_d = 1'b0;

    case (st_q)
      c8_pkg::StClear: begin
        // memory and frame buffer sweep after reset
        m_we = 1'b1; m_addr = cnt_q; m_wd = c8_pkg::font_byte(cnt_q[6:0]);
        if (cnt_q >= 12'(c8_pkg::FontBytes)) m_wd = 8'h00;
        f_we = 1'b1; f_addr = cnt_q[10:0];
        cnt_d = cnt_q + 12'd1;
        if (cnt_q == 12'hFFF) st_d = c8_pkg::StIdle;
      end
      c8_pkg::StIdle: begin
        in_ready_o = !out_v_q;
        if (in_valid_i && !out_v_q) begin
          in_d = in_data_i;
          res_d = '0;
          case (in_data_i.func)
            c8_pkg::FuncLoad: begin
              m_we = 1'b1; m_addr = in_data_i.load_address; m_wd = in_data_i.load_byte;
              st_d = c8_pkg::StDone;
            end
            c8_pkg::FuncExec: st_d = c8_pkg::StFetchHi;
            c8_pkg::FuncPixel: st_d = c8_pkg::StFbRead;
            default: st_d = c8_pkg::StDone;
          endcase
        end
      end
      c8_pkg::StFbRead: st_d = c8_pkg::StPixW;
      c8_pkg::StPixW: begin
        res_d.pixel_value = f_rd;
        st_d = c8_pkg::StDone;
      end
      c8_pkg::StFetchHi: begin
        m_addr = pc_q; st_d = c8_pkg::StFetchLo;
      end
      c8_pkg::StFetchLo: begin
        // high byte arrives while the low byte address goes out
        m_addr = pc_q + 12'd1; op_d[15:8] = m_rd; st_d = c8_pkg::StOpLo;
      end
      c8_pkg::StOpLo: begin
        m_addr = pc_q + 12'd1; st_d = c8_pkg::StExec;
      end
      c8_pkg::StExec: begin
        logic [15:0] op;
        op = {op_q[15:8], m_rd};
        op_d = op;
        pc_d = pc_q + 12'd2;
        chg_d = 1'b0;
        coll_d = 1'b0;
        cnt_d = '0; col_d = '0; ph_d = 1'b0;
        st_d = c8_pkg::StTimers;
        // decode uses op directly; x/y fields via op
        case (c8_pkg::op_group_e'(op[15:12]))
          c8_pkg::OpSys: begin
            if (op[7:0] == c8_pkg::SysRet) begin
              sp_d = sp_q - 4'd1;
              pc_d = stk_q[sp_q - 4'd1] + 12'd2;
            end else if (op[7:0] == c8_pkg::SysCls) begin
              chg_d = 1'b1; st_d = c8_pkg::StClrFb;
            end
          end
          c8_pkg::OpJump: pc_d = op[11:0];
          c8_pkg::OpCall: begin
            stk_d[sp_q] = pc_q; sp_d = sp_q + 4'd1; pc_d = op[11:0];
          end
          c8_pkg::OpSkipEqImm: if (v_q[op[11:8]] == op[7:0]) pc_d = pc_q + 12'd4;
          c8_pkg::OpSkipNeImm: if (v_q[op[11:8]] != op[7:0]) pc_d = pc_q + 12'd4;
          c8_pkg::OpSkipEqReg: if (v_q[op[11:8]] == v_q[op[7:4]]) pc_d = pc_q + 12'd4;
          c8_pkg::OpLoadImm: v_d[op[11:8]] = op[7:0];
          c8_pkg::OpAddImm: v_d[op[11:8]] = v_q[op[11:8]] + op[7:0];
          c8_pkg::OpAlu: begin
            logic [7:0] a, b;
            a = v_q[op[11:8]]; b = v_q[op[7:4]];
            case (op[3:0])
              c8_pkg::AluMov: v_d[op[11:8]] = b;
              c8_pkg::AluOr:  v_d[op[11:8]] = a | b;
              c8_pkg::AluAnd: v_d[op[11:8]] = a & b;
              c8_pkg::AluXor: v_d[op[11:8]] = a ^ b;
              c8_pkg::AluAdd: begin
                a9 = {1'b0, a} + {1'b0, b};
                v_d[15] = {7'd0, a9[8]};
                if (op[11:8] == 4'hF) a = {7'd0, a9[8]};
                if (op[7:4] == 4'hF) b = {7'd0, a9[8]};
                v_d[op[11:8]] = a + b;
              end
              c8_pkg::AluSub: begin
                v_d[15] = {7'd0, a > b};
                if (op[11:8] == 4'hF) a = {7'd0, a > b};
                if (op[7:4] == 4'hF) b = {7'd0, v_q[op[11:8]] > v_q[op[7:4]]};
                v_d[op[11:8]] = a - b;
              end
              c8_pkg::AluShr: begin
                v_d[15] = {7'd0, a[0]};
                if (op[11:8] == 4'hF) a = {7'd0, a[0]};
                v_d[op[11:8]] = a >> 1;
              end
              c8_pkg::AluSubn: begin
                v_d[15] = {7'd0, b > a};
                if (op[11:8] == 4'hF) a = {7'd0, b > a};
                if (op[7:4] == 4'hF) b = {7'd0, v_q[op[7:4]] > v_q[op[11:8]]};
                v_d[op[11:8]] = b - a;
              end
              c8_pkg::AluShl: begin
                v_d[15] = {7'd0, a[7]};
                if (op[11:8] == 4'hF) a = {7'd0, a[7]};
                v_d[op[11:8]] = a << 1;
              end
              default: ;
            endcase
          end
          c8_pkg::OpSkipNeReg: if (v_q[op[11:8]] != v_q[op[7:4]]) pc_d = pc_q + 12'd4;
          c8_pkg::OpLoadIndex: i_d = {4'd0, op[11:0]};
          c8_pkg::OpJumpV0: pc_d = op[11:0] + {4'd0, v_q[0]};
          c8_pkg::OpRand: v_d[op[11:8]] = rnd9[7:0] & op[7:0];
          c8_pkg::OpDraw: begin
            // vf stays put during the draw so a flag coordinate reads its old value
            chg_d = 1'b1;
            if (op[3:0] != 4'd0) st_d = c8_pkg::StDrawMem;
          end
          c8_pkg::OpKey: begin
            logic held;
            held = (v_q[op[11:8]][7:4] == 4'd0) && in_q.key_states[v_q[op[11:8]][3:0]];
            if (op[7:0] == c8_pkg::KeySkp && held) pc_d = pc_q + 12'd4;
            if (op[7:0] == c8_pkg::KeySknp && !held) pc_d = pc_q + 12'd4;
          end
          c8_pkg::OpMisc: begin
            case (op[7:0])
              c8_pkg::MiscGetDt: v_d[op[11:8]] = dt_q;
              c8_pkg::MiscSetDt: dt_d = v_q[op[11:8]];
              c8_pkg::MiscSetSt: snd_d = v_q[op[11:8]];
              c8_pkg::MiscAddI: begin
                sum = {1'b0, i_q[11:0]} + {5'd0, v_q[op[11:8]]};
                v_d[15] = {7'd0, (i_q[15:12] != 4'd0) || sum[12]};
                i_d = i_q + {8'd0, v_q[op[11:8]]};
              end
              c8_pkg::MiscFont: i_d = {8'd0, v_q[op[11:8]]} * 16'd5;
              c8_pkg::MiscBcd: st_d = c8_pkg::StBcd;
              c8_pkg::MiscStore: st_d = c8_pkg::StStore;
              c8_pkg::MiscLoad: st_d = c8_pkg::StLoad;
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      c8_pkg::StClrFb: begin
        f_we = 1'b1; f_addr = cnt_q[10:0];
        cnt_d = cnt_q + 12'd1;
        if (cnt_q[10:0] == 11'h7FF) st_d = c8_pkg::StTimers;
      end
      c8_pkg::StDrawMem: begin
        m_addr = i_q[11:0] + cnt_q; st_d = c8_pkg::StDrawMemW;
      end
      c8_pkg::StDrawMemW: begin
        m_addr = i_q[11:0] + cnt_q; st_d = c8_pkg::StDrawRow;
      end
      c8_pkg::StDrawRow: begin
        bits_d = m_rd; col_d = '0; st_d = c8_pkg::StDrawPix;
      end
      c8_pkg::StDrawPix: begin
        // read pixel, then write toggled value
        f_addr = {row_pos[4:0], col_pos[5:0]};
        if (row_pos < 9'(c8_pkg::ScreenH) && col_pos < 9'(c8_pkg::ScreenW) &&
            bits_q[3'd7 - col_q]) st_d = c8_pkg::StDrawPixW;
        else if (col_q == 3'd7) begin
          cnt_d = cnt_q + 12'd1;
          st_d = (cnt_q[3:0] + 4'd1 == op_q[3:0]) ? c8_pkg::StTimers : c8_pkg::StDrawMem;
        end else col_d = col_q + 3'd1;
      end
      c8_pkg::StDrawPixW: begin
        if (ph_q) begin
          f_addr = {row_pos[4:0], col_pos[5:0]};
          f_we = 1'b1; f_wd = !f_rd;
          if (f_rd) coll_d = 1'b1;
          ph_d = 1'b0;
          if (col_q == 3'd7) begin
            cnt_d = cnt_q + 12'd1;
            st_d = (cnt_q[3:0] + 4'd1 == op_q[3:0]) ? c8_pkg::StTimers : c8_pkg::StDrawMem;
          end else begin
            col_d = col_q + 3'd1; st_d = c8_pkg::StDrawPix;
          end
        end else begin
          f_addr = {row_pos[4:0], col_pos[5:0]};
          ph_d = 1'b1;
        end
      end
      c8_pkg::StBcd: begin
        m_we = 1'b1; m_addr = i_q[11:0] + cnt_q;
        m_wd = (cnt_q[1:0] == 2'd0) ? bcd_h : (cnt_q[1:0] == 2'd1) ? bcd_t
             : bcd_o - 8'(bcd_t * 8'd10);
        cnt_d = cnt_q + 12'd1;
        if (cnt_q[1:0] == 2'd2) st_d = c8_pkg::StTimers;
      end
      c8_pkg::StStore: begin
        m_we = 1'b1; m_addr = i_q[11:0] + cnt_q; m_wd = v_q[cnt_q[3:0]];
        cnt_d = cnt_q + 12'd1;
        if (cnt_q[3:0] == x) begin
          i_d = i_q + {12'd0, x} + 16'd1; st_d = c8_pkg::StTimers;
        end
      end
      c8_pkg::StLoad: begin
        m_addr = i_q[11:0] + cnt_q; st_d = c8_pkg::StLoadW;
      end
      c8_pkg::StLoadW: begin
        if (ph_q) begin
          v_d[cnt_q[3:0]] = m_rd; ph_d = 1'b0;
          cnt_d = cnt_q + 12'd1;
          if (cnt_q[3:0] == x) begin
            i_d = i_q + {12'd0, x} + 16'd1; st_d = c8_pkg::StTimers;
          end else st_d = c8_pkg::StLoad;
        end else begin
          m_addr = i_q[11:0] + cnt_q; ph_d = 1'b1;
        end
      end
      c8_pkg::StTimers: begin
        // a finished draw writes its collision flag
        if (c8_pkg::op_group_e'(op_q[15:12]) == c8_pkg::OpDraw) v_d[15] = {7'd0, coll_q};
        if (dt_q != 8'd0) dt_d = dt_q - 8'd1;
        if (snd_q != 8'd0) snd_d = snd_q - 8'd1;
        res_d.beep = (snd_q == 8'd1);
        res_d.opcode = op_q;
        res_d.screen_changed = chg_q;
        st_d = c8_pkg::StDone;
      end
      c8_pkg::StDone: begin
        res_d.program_counter = pc_q;
        out_v_d = 1'b1;
        st_d = c8_pkg::StIdle;
      end
      default: st_d = c8_pkg::StIdle;
    endcase
  end

  assign out_valid_o = out_v_q;
  assign out_data_o = res_q;
endmodule
